/* rtl/core/lrx_pkg.sv */
// Package for the layered radiation exchange solver.
// Holds the word formats, per-layer row types, sequencer states and fixed-point constants.
// Used by layered_radiation_exchange_solver; depends on nothing else.
package lrx_pkg;

   localparam int DEFAULT_MAX_LAYERS = 16;
   localparam int COEF_W = 17;
   localparam int FLUX_W = 20;
   localparam int PASS_W = 8;
   localparam int LNUM_W = 4;
   localparam int PROD_W = 54;
   localparam int DIVD_W = 38;

   localparam logic [COEF_W-1:0] COEF_ONE = 17'd65536;
   localparam logic [FLUX_W-1:0] FLUX_MAX = 20'hFFFFF;

   // Configuration register indexes.
   localparam logic CSR_THRESHOLD  = 1'b0;
   localparam logic CSR_MAX_PASSES = 1'b1;

   typedef struct packed {
      logic [COEF_W-1:0] absorb_from_above;
      logic [COEF_W-1:0] reflect_from_above;
      logic [COEF_W-1:0] transmit_from_above;
      logic [COEF_W-1:0] absorb_from_below;
      logic [COEF_W-1:0] reflect_from_below;
      logic [COEF_W-1:0] transmit_from_below;
      logic [FLUX_W-1:0] emit_down;
      logic [FLUX_W-1:0] emit_up;
      logic [FLUX_W-1:0] start_absorbed_above;
      logic [FLUX_W-1:0] start_absorbed_below;
      logic              last_layer;
   } req_word_type;

   typedef struct packed {
      logic [LNUM_W-1:0] layer_number;
      logic [FLUX_W-1:0] absorbed_above;
      logic [FLUX_W-1:0] absorbed_below;
      logic [PASS_W-1:0] passes_used;
      logic              converged;
      logic              last_result;
   } rsp_word_type;

   typedef struct packed {
      logic [COEF_W-1:0] absorb_down;
      logic [COEF_W-1:0] reflect_down;
      logic [COEF_W-1:0] transmit_down;
      logic [COEF_W-1:0] absorb_up;
      logic [COEF_W-1:0] reflect_up;
      logic [COEF_W-1:0] transmit_up;
   } coef_row_type;

   typedef struct packed {
      logic [FLUX_W-1:0] flow_down;
      logic [FLUX_W-1:0] flow_up;
      logic [FLUX_W-1:0] abs_down;
      logic [FLUX_W-1:0] abs_up;
   } flux_row_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_PASS,
      ST_RD_CUR,
      ST_RD_NX,
      ST_K_MUL,
      ST_K_SET,
      ST_SH_MUL1,
      ST_SH_MUL2,
      ST_SH_DIV_INIT,
      ST_SH_DIV,
      ST_SH_ADD,
      ST_WR_CUR,
      ST_WR_NX,
      ST_RES_RD,
      ST_RES_ADD,
      ST_CHECK,
      ST_OUT_RD,
      ST_OUT_SET,
      ST_OUT_WAIT
   } lrx_state_type;

   function automatic logic [COEF_W-1:0] clamp_coef(input logic [COEF_W-1:0] v);
      return (v > COEF_ONE) ? COEF_ONE : v;
   endfunction

   function automatic logic [FLUX_W-1:0] sat_add(input logic [FLUX_W-1:0] a,
                                                 input logic [FLUX_W-1:0] b);
      logic [FLUX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[FLUX_W] ? FLUX_MAX : s[FLUX_W-1:0];
   endfunction

endpackage

/* rtl/core/layered_radiation_exchange_solver.sv */
// Top level of the layered radiation exchange solver.
// One sequencer drives a shared multiplier and a bit-serial divider over two row memories.
// Depends on lrx_pkg.
//
// Usage: layers arrive on the req channel (valid/ready), one word per layer, top first.
// A word without last_layer is stored when it is accepted. The word with last_layer is stored
// and starts the solve; req_ready stays low until the last result has been taken.
// Each pass visits every neighbor pair twice (down, then up). Each pair visit does
// two row reads, one multiply for k, four shares of one or two multiplies and a
// restoring division each (skipped when the quotient saturates), then two row writes.
// The residual sum then adds up the remaining flows of every layer.
// Results leave on the rsp channel, one word per layer, top first, from an output
// register, and the sequencer waits while the receiver holds rsp_ready low.
// Configuration (threshold, pass cap) is written through the csr port while idle.
// Reset puts the sequencer, loaded count and control and csr registers at their defaults;
// layer memories hold no reset value and only layers loaded since the last solve are read.
module layered_radiation_exchange_solver #(
   parameter int MAX_LAYERS = lrx_pkg::DEFAULT_MAX_LAYERS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lrx_pkg::req_word_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lrx_pkg::rsp_word_type rsp_word,
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [lrx_pkg::FLUX_W-1:0] csr_data
);
   import lrx_pkg::*;

   localparam int IDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int CNT_W = $clog2(MAX_LAYERS + 1);
   localparam int RES_W = FLUX_W + 1 + IDX_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LAYERS);

   coef_row_type coef_mem [MAX_LAYERS];
   flux_row_type flux_mem [MAX_LAYERS];
   coef_row_type coef_rd_ff;
   flux_row_type flux_rd_ff;

   lrx_state_type state_ff, state_in;
   logic [CNT_W-1:0]  loaded_ff, loaded_in;
   logic [CNT_W-1:0]  nlay_ff, nlay_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic              dir_ff, dir_in;
   logic [1:0]        idx_ff, idx_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic              conv_ff, conv_in;
   logic [FLUX_W-1:0] thr_ff, thr_in;
   logic [PASS_W-1:0] cap_ff, cap_in;
   coef_row_type      cc_ff, cc_in, nc_ff, nc_in;
   flux_row_type      cs_ff, cs_in, ns_ff, ns_in;
   logic [COEF_W-1:0] k_ff, k_in;
   logic [PROD_W-1:0] mul_ff, mul_in;
   logic [COEF_W-1:0] rem_ff, rem_in;
   logic [FLUX_W-1:0] q_ff, q_in;
   logic [4:0]        bit_ff, bit_in;
   logic [RES_W-1:0]  sum_ff, sum_in;
   rsp_word_type      rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic              coef_we, flux_we;
   coef_row_type      coef_wdata;
   flux_row_type      flux_wdata;

   logic [IDX_W-1:0]  nx_idx, last_idx;
   logic              nx_is_end, cur_is_last;
   logic [36:0]       mul_a;
   logic [COEF_W-1:0] mul_b;
   logic [COEF_W-1:0] r_near, r_cur, c_sel;
   logic [FLUX_W-1:0] f_sel;
   logic [17:0]       p_round, k_tmp;
   logic [DIVD_W-1:0] dividend;
   logic [17:0]       trial;
   logic              trial_ge;
   logic [PASS_W-1:0] cap_eff;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign nx_idx      = dir_ff ? (cur_ff - 1'b1) : (cur_ff + 1'b1);
   assign last_idx    = IDX_W'(nlay_ff - 1'b1);
   assign nx_is_end   = dir_ff ? (nx_idx == '0) : (nx_idx == last_idx);
   assign cur_is_last = (cur_ff == last_idx);
   assign cap_eff     = (cap_ff == '0) ? PASS_W'(1) : cap_ff;

   // Neighbor-facing reflectances and the flow that leaves the current layer.
   assign r_near = dir_ff ? nc_ff.reflect_up : nc_ff.reflect_down;
   assign r_cur  = dir_ff ? cc_ff.reflect_down : cc_ff.reflect_up;
   assign f_sel  = dir_ff ? cs_ff.flow_up : cs_ff.flow_down;

   always_comb begin
      case (idx_ff)
         2'd0:    c_sel = dir_ff ? nc_ff.absorb_up : nc_ff.absorb_down;
         2'd1:    c_sel = dir_ff ? nc_ff.transmit_up : nc_ff.transmit_down;
         2'd2:    c_sel = dir_ff ? cc_ff.absorb_down : cc_ff.absorb_up;
         default: c_sel = dir_ff ? cc_ff.transmit_down : cc_ff.transmit_up;
      endcase
   end

   assign p_round  = 18'((mul_ff[33:0] + 34'd32768) >> 16);
   assign k_tmp    = 18'd65536 - p_round;
   // Reflected shares divide by k * 65536, which equals dividing the shifted product by k.
   assign dividend = idx_ff[1] ? mul_ff[53:16] : {1'b0, mul_ff[36:0]};
   assign trial    = {rem_ff, q_ff[FLUX_W-1]};
   assign trial_ge = (trial >= {1'b0, k_ff});

   always_comb begin
      mul_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      nlay_in      = nlay_ff;
      cur_in       = cur_ff;
      dir_in       = dir_ff;
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      conv_in      = conv_ff;
      thr_in       = thr_ff;
      cap_in       = cap_ff;
      cc_in        = cc_ff;
      nc_in        = nc_ff;
      cs_in        = cs_ff;
      ns_in        = ns_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      bit_in       = bit_ff;
      sum_in       = sum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_a        = {20'd0, r_near};
      mul_b        = r_cur;
      rd_addr      = cur_ff;
      wr_addr      = cur_ff;
      coef_we      = 1'b0;
      flux_we      = 1'b0;
      coef_wdata.absorb_down   = clamp_coef(req_word.absorb_from_above);
      coef_wdata.reflect_down  = clamp_coef(req_word.reflect_from_above);
      coef_wdata.transmit_down = clamp_coef(req_word.transmit_from_above);
      coef_wdata.absorb_up     = clamp_coef(req_word.absorb_from_below);
      coef_wdata.reflect_up    = clamp_coef(req_word.reflect_from_below);
      coef_wdata.transmit_up   = clamp_coef(req_word.transmit_from_below);
      flux_wdata.flow_down     = req_word.emit_down;
      flux_wdata.flow_up       = req_word.emit_up;
      flux_wdata.abs_down      = req_word.start_absorbed_above;
      flux_wdata.abs_up        = req_word.start_absorbed_below;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_THRESHOLD:  thr_in = csr_data;
            CSR_MAX_PASSES: cap_in = csr_data[PASS_W-1:0];
            default:        thr_in = thr_ff;
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            wr_addr = loaded_ff[IDX_W-1:0];
            if (req_valid) begin
               if (loaded_ff < CNT_MAX) begin
                  coef_we   = 1'b1;
                  flux_we   = 1'b1;
                  loaded_in = loaded_ff + 1'b1;
               end
               if (req_word.last_layer) begin
                  nlay_in   = loaded_in;
                  loaded_in = '0;
                  pass_in   = '0;
                  state_in  = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            pass_in = pass_ff + 1'b1;
            sum_in  = '0;
            cur_in  = '0;
            dir_in  = 1'b0;
            state_in = (nlay_ff >= CNT_W'(2)) ? ST_RD_CUR : ST_RES_RD;
         end
         ST_RD_CUR: begin
            rd_addr  = cur_ff;
            state_in = ST_RD_NX;
         end
         ST_RD_NX: begin
            cc_in    = coef_rd_ff;
            cs_in    = flux_rd_ff;
            rd_addr  = nx_idx;
            state_in = ST_K_MUL;
         end
         ST_K_MUL: begin
            // The neighbor row is still on the read port, so its reflectance comes from there.
            mul_a    = {20'd0, dir_ff ? coef_rd_ff.reflect_up : coef_rd_ff.reflect_down};
            nc_in    = coef_rd_ff;
            ns_in    = flux_rd_ff;
            state_in = ST_K_SET;
         end
         ST_K_SET: begin
            // r_near and r_cur now come from captured rows; mul_ff holds their product.
            k_in     = (k_tmp == '0) ? COEF_W'(1) : k_tmp[COEF_W-1:0];
            idx_in   = 2'd0;
            state_in = ST_SH_MUL1;
         end
         ST_SH_MUL1: begin
            mul_a    = {17'd0, f_sel};
            mul_b    = c_sel;
            state_in = idx_ff[1] ? ST_SH_MUL2 : ST_SH_DIV_INIT;
         end
         ST_SH_MUL2: begin
            mul_a    = mul_ff[36:0];
            mul_b    = r_near;
            state_in = ST_SH_DIV_INIT;
         end
         ST_SH_DIV_INIT: begin
            if (dividend[DIVD_W-1:FLUX_W] >= {1'b0, k_ff}) begin
               q_in     = FLUX_MAX;
               state_in = ST_SH_ADD;
            end else begin
               rem_in   = dividend[FLUX_W+COEF_W-1:FLUX_W];
               q_in     = dividend[FLUX_W-1:0];
               bit_in   = '0;
               state_in = ST_SH_DIV;
            end
         end
         ST_SH_DIV: begin
            rem_in = trial_ge ? COEF_W'(trial - {1'b0, k_ff}) : trial[COEF_W-1:0];
            q_in   = {q_ff[FLUX_W-2:0], trial_ge};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 5'(FLUX_W - 1)) begin
               state_in = ST_SH_ADD;
            end
         end
         ST_SH_ADD: begin
            case (idx_ff)
               2'd0: begin
                  if (dir_ff) ns_in.abs_up = sat_add(ns_ff.abs_up, q_ff);
                  else ns_in.abs_down = sat_add(ns_ff.abs_down, q_ff);
               end
               2'd1: begin
                  if (dir_ff) ns_in.flow_up = sat_add(ns_ff.flow_up, q_ff);
                  else ns_in.flow_down = sat_add(ns_ff.flow_down, q_ff);
               end
               2'd2: begin
                  if (dir_ff) cs_in.abs_down = sat_add(cs_ff.abs_down, q_ff);
                  else cs_in.abs_up = sat_add(cs_ff.abs_up, q_ff);
               end
               default: begin
                  if (dir_ff) cs_in.flow_down = sat_add(cs_ff.flow_down, q_ff);
                  else cs_in.flow_up = sat_add(cs_ff.flow_up, q_ff);
               end
            endcase
            idx_in   = idx_ff + 1'b1;
            state_in = (idx_ff == 2'd3) ? ST_WR_CUR : ST_SH_MUL1;
         end
         ST_WR_CUR: begin
            // The flow that just left this layer is gone.
            flux_we    = 1'b1;
            wr_addr    = cur_ff;
            flux_wdata = cs_ff;
            if (dir_ff) flux_wdata.flow_up = '0;
            else flux_wdata.flow_down = '0;
            state_in   = ST_WR_NX;
         end
         ST_WR_NX: begin
            flux_we    = 1'b1;
            wr_addr    = nx_idx;
            flux_wdata = ns_ff;
            if (!nx_is_end) begin
               cur_in   = nx_idx;
               state_in = ST_RD_CUR;
            end else if (!dir_ff) begin
               dir_in   = 1'b1;
               cur_in   = last_idx;
               state_in = ST_RD_CUR;
            end else begin
               cur_in   = '0;
               state_in = ST_RES_RD;
            end
         end
         ST_RES_RD: begin
            rd_addr  = cur_ff;
            state_in = ST_RES_ADD;
         end
         ST_RES_ADD: begin
            sum_in = sum_ff + RES_W'(flux_rd_ff.flow_down) + RES_W'(flux_rd_ff.flow_up);
            if (cur_is_last) begin
               state_in = ST_CHECK;
            end else begin
               cur_in   = cur_ff + 1'b1;
               state_in = ST_RES_RD;
            end
         end
         ST_CHECK: begin
            cur_in = '0;
            if (sum_ff <= RES_W'(thr_ff)) begin
               conv_in  = 1'b1;
               state_in = ST_OUT_RD;
            end else if (pass_ff >= cap_eff) begin
               conv_in  = 1'b0;
               state_in = ST_OUT_RD;
            end else begin
               state_in = ST_PASS;
            end
         end
         ST_OUT_RD: begin
            rd_addr  = cur_ff;
            state_in = ST_OUT_SET;
         end
         ST_OUT_SET: begin
            rsp_in.layer_number   = LNUM_W'(cur_ff);
            rsp_in.absorbed_above = flux_rd_ff.abs_down;
            rsp_in.absorbed_below = flux_rd_ff.abs_up;
            rsp_in.passes_used    = pass_ff;
            rsp_in.converged      = conv_ff;
            rsp_in.last_result    = cur_is_last;
            rsp_valid_in          = 1'b1;
            state_in              = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (cur_is_last) begin
                  state_in = ST_LOAD;
               end else begin
                  cur_in   = cur_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         loaded_ff    <= '0;
         nlay_ff      <= '0;
         cur_ff       <= '0;
         dir_ff       <= 1'b0;
         idx_ff       <= '0;
         pass_ff      <= '0;
         conv_ff      <= 1'b0;
         thr_ff       <= FLUX_W'(1);
         cap_ff       <= PASS_W'(255);
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         nlay_ff      <= nlay_in;
         cur_ff       <= cur_in;
         dir_ff       <= dir_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
         conv_ff      <= conv_in;
         thr_ff       <= thr_in;
         cap_ff       <= cap_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cc_ff  <= cc_in;
      nc_ff  <= nc_in;
      cs_ff  <= cs_in;
      ns_ff  <= ns_in;
      k_ff   <= k_in;
      mul_ff <= mul_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      sum_ff <= sum_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[wr_addr] <= coef_wdata;
      end
      coef_rd_ff <= coef_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (flux_we) begin
         flux_mem[wr_addr] <= flux_wdata;
      end
      flux_rd_ff <= flux_mem[rd_addr];
   end

endmodule
